FILE: hw/rtl/upi_pkg.sv
// Package for the unicycle pose integrator: payload structs, register
// indexes, CORDIC constants and arctangent table. No dependencies.
package upi_pkg;

    localparam int CS_W    = 20;   // rounded cos/sin width, Q2.16 plus headroom
    localparam int CV_W    = 34;   // CORDIC vector/angle width
    localparam int ACC_W   = 54;   // speed * dt * cos product
    localparam int IDX_W   = 8;    // config register index width
    localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [IDX_W-1:0] REG_TIME_STEP = 8'd0;
    localparam logic [IDX_W-1:0] REG_INIT_X    = 8'd1;
    localparam logic [IDX_W-1:0] REG_INIT_Y    = 8'd2;
    localparam logic [IDX_W-1:0] REG_INIT_HEAD = 8'd3;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] speed;
        logic signed [23:0] turn_rate;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic        [31:0] elapsed_time;
        logic               saturated;
    } out_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/upi_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on upi_pkg.
module upi_cordic import upi_pkg::*; #(
    parameter int ITER = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [15:0]            heading,
    output logic                   busy,
    output logic                   done,
    output logic signed [CS_W-1:0] cos_o,
    output logic signed [CS_W-1:0] sin_o
);
    localparam int CNT_W = $clog2(ITER + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   flip_reg, flip_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [CV_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [CS_W-1:0] cos_reg, cos_next, sin_reg, sin_next;

    logic signed [CV_W-1:0] xs, ys, at, xf, yf, xr, yr;
    logic                   flip;

    always_comb begin
        flip = heading[15] ^ heading[14];
        xs   = x_reg >>> cnt_reg;
        ys   = y_reg >>> cnt_reg;
        at   = CV_W'(signed'({1'b0, atan_lookup(5'(cnt_reg))}));
        xf   = flip_reg ? -x_reg : x_reg;
        yf   = flip_reg ? -y_reg : y_reg;
        xr   = xf + CV_W'(8192);
        yr   = yf + CV_W'(8192);

        busy_next = busy_reg;
        done_next = 1'b0;
        flip_next = flip_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            flip_next = flip;
            cnt_next  = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            // half turn folds quadrants two and three onto the right half plane
            z_next    = CV_W'(signed'({heading[15] ^ flip, heading[14:0], 16'b0}));
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(ITER)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = xr[CV_W-1:14];
                sin_next  = yr[CV_W-1:14];
            end else begin
                cnt_next = cnt_reg + 1'b1;
                if (!z_reg[CV_W-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        flip_reg <= flip_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

FILE: hw/rtl/unicycle_pose_integrator.sv
// Unicycle pose integrator top: config registers, pose state, bit-serial
// multiply of speed*dt by cos/sin. Depends on upi_pkg and upi_cordic.
//
//  channel | ports                          | request
//  input   | s_valid s_ready s_data (in_t)  | one step or load item
//  result  | m_valid m_ready m_data (out_t) | pose after the item
//  config  | cfg_valid cfg_ready cfg_index  | register write
//          | cfg_data                       |
//
// Integrate item: CORDIC rotation (one micro-rotation per cycle), then a serial
// multiply over the cos/sin bits. Load item: taken straight to the done state.
// One item in flight; a finished result waits in the output register and the
// next item is taken meanwhile up to its final write.
// Reset clears pose and time and loads time_step = 1638. Config always ready.
module unicycle_pose_integrator import upi_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_ROT  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    in_t    in_reg;
    logic [15:0]        ts_reg, ih_reg;
    logic signed [31:0] ix_reg, iy_reg;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [15:0]        hd_reg, hd_next;
    logic [31:0]        tm_reg, tm_next;
    logic signed [32:0] prod_reg;
    logic [15:0]        dh_reg;
    logic signed [ACC_W-1:0] mc_reg, ax_reg, ay_reg;
    logic [CS_W-1:0]    cx_reg, cy_reg;
    logic [4:0]         bit_cnt_reg;
    out_t               out_reg;
    logic               m_valid_reg;

    logic cor_start, cor_busy, cor_done;
    logic signed [CS_W-1:0] cor_cos, cor_sin;

    upi_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .heading (hd_reg),
        .busy    (cor_busy),
        .done    (cor_done),
        .cos_o   (cor_cos),
        .sin_o   (cor_sin)
    );

    logic               s_fire, out_free, last_bit;
    logic signed [40:0] dh_full;
    logic signed [ACC_W-1:0] rx, ry;
    logic signed [32:0] sx, sy;
    logic [32:0]        tsum;
    logic               clip;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign cor_start = (state_reg == ST_PREP);
    assign last_bit  = (bit_cnt_reg == 5'(CS_W - 1));

    always_comb begin
        dh_full = in_reg.turn_rate * $signed({1'b0, ts_reg}) + 41'sd32768;
        rx   = ax_reg + ACC_W'(1 << 23);
        ry   = ay_reg + ACC_W'(1 << 23);
        sx   = 33'(px_reg) + 33'($signed(rx[ACC_W-1:24]));
        sy   = 33'(py_reg) + 33'($signed(ry[ACC_W-1:24]));
        tsum = {1'b0, tm_reg} + 33'(ts_reg);

        px_next = px_reg;
        py_next = py_reg;
        hd_next = hd_reg;
        tm_next = tm_reg;
        clip    = 1'b0;
        if (in_reg.opcode == OP_LOAD) begin
            px_next = ix_reg;
            py_next = iy_reg;
            hd_next = ih_reg;
            tm_next = '0;
        end else begin
            if (sx[32] != sx[31]) begin
                clip    = 1'b1;
                px_next = sx[32] ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
                px_next = sx[31:0];
            end
            if (sy[32] != sy[31]) begin
                clip    = 1'b1;
                py_next = sy[32] ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
                py_next = sy[31:0];
            end
            hd_next = hd_reg + dh_reg;
            if (tsum[32]) begin
                clip    = 1'b1;
                tm_next = '1;
            end else begin
                tm_next = tsum[31:0];
            end
        end

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) begin
                state_next = (s_data.opcode == OP_LOAD) ? ST_DONE : ST_PREP;
            end
            ST_PREP: state_next = ST_ROT;
            ST_ROT:  if (cor_done) state_next = ST_MUL;
            ST_MUL:  if (last_bit) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ts_reg      <= 16'd1638;
            ix_reg      <= '0;
            iy_reg      <= '0;
            ih_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            hd_reg      <= '0;
            tm_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TIME_STEP: ts_reg <= cfg_data[15:0];
                    REG_INIT_X:    ix_reg <= cfg_data;
                    REG_INIT_Y:    iy_reg <= cfg_data;
                    REG_INIT_HEAD: ih_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                px_reg      <= px_next;
                py_reg      <= py_next;
                hd_reg      <= hd_next;
                tm_reg      <= tm_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) in_reg <= s_data;
        if (state_reg == ST_PREP) begin
            prod_reg <= in_reg.speed * $signed({1'b0, ts_reg});
            dh_reg   <= dh_full[31:16];
        end
        if (state_reg == ST_ROT && cor_done) begin
            mc_reg      <= ACC_W'(prod_reg);
            cx_reg      <= cor_cos;
            cy_reg      <= cor_sin;
            ax_reg      <= '0;
            ay_reg      <= '0;
            bit_cnt_reg <= '0;
        end
        if (state_reg == ST_MUL) begin
            // two's complement: the top bit of cos/sin carries negative weight
            if (cx_reg[0]) ax_reg <= last_bit ? ax_reg - mc_reg : ax_reg + mc_reg;
            if (cy_reg[0]) ay_reg <= last_bit ? ay_reg - mc_reg : ay_reg + mc_reg;
            mc_reg      <= mc_reg <<< 1;
            cx_reg      <= cx_reg >> 1;
            cy_reg      <= cy_reg >> 1;
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        if (state_reg == ST_DONE && out_free) begin
            out_reg.pos_x        <= px_next;
            out_reg.pos_y        <= py_next;
            out_reg.heading      <= hd_next;
            out_reg.elapsed_time <= tm_next;
            out_reg.saturated    <= clip;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_cordic_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_start |-> !cor_busy) else $error("cordic started while busy");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready) else $error("second request taken while busy");
    a_load_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && in_reg.opcode == OP_LOAD)
        |=> (m_valid && !m_data.saturated)) else $error("load reported clipping");
    a_mul_after_cordic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> !cor_busy) else $error("multiply overlaps cordic");

endmodule

FILE: sim/unicycle_pose_integrator_tb.sv
// Self-checking testbench for unicycle_pose_integrator: a directed table, then
// random phases, each result checked against its typed expected pose or else
// against a behavioral pose predictor. Depends on upi_pkg and the RTL top.
`timescale 1ns / 100ps

module unicycle_pose_integrator_tb;
    import upi_pkg::*;

    localparam int  ROTATIONS   = 16;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  SETTLE      = 60;
    localparam int  PHASE_ITEMS = 75;

    typedef struct {
        bit                is_cfg;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       val;
        in_t               item;
        bit                typed;
        out_t              want;
    } dir_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [31:0]      cfg_data;

    // predictor copy of registers and pose
    logic [15:0]        pm_dt;
    logic signed [31:0] pm_init_x, pm_init_y;
    logic [15:0]        pm_init_h;
    logic signed [31:0] pm_x, pm_y;
    logic [15:0]        pm_h;
    logic [31:0]        pm_time;

    out_t     pose_q[$];
    dir_row_t dir_tab[$];
    int       err_cnt;
    int       cycle_cnt;
    bit       s_calm, m_calm;
    int       m_stall;

    longint atan_q30 [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    unicycle_pose_integrator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void heading_sincos(input logic [15:0] h, output longint c,
                                           output longint s);
        logic [31:0] a;
        longint      x, y, z, xs, ys;
        bit          flip;
        a    = {h, 16'h0000};
        flip = a[31] ^ a[30];
        if (flip) a[31] = ~a[31];
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_q30[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_q30[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic out_t advance_pose(input in_t d);
        out_t   r;
        bit     clipped;
        longint c, s, dt, dx, dy, dh, t;
        clipped = 1'b0;
        if (d.opcode == OP_LOAD) begin
            pm_x = pm_init_x; pm_y = pm_init_y; pm_h = pm_init_h; pm_time = '0;
        end else begin
            dt = longint'({48'd0, pm_dt});
            heading_sincos(pm_h, c, s);
            dx = (longint'(d.speed) * c * dt + (64'sd1 <<< 23)) >>> 24;
            dy = (longint'(d.speed) * s * dt + (64'sd1 <<< 23)) >>> 24;
            pm_x = clip32(longint'(pm_x) + dx, clipped);
            pm_y = clip32(longint'(pm_y) + dy, clipped);
            dh = (longint'(d.turn_rate) * dt + 32768) >>> 16;
            pm_h = pm_h + dh[15:0];
            t = longint'({32'd0, pm_time}) + dt;
            if (t > 64'sh00000000FFFFFFFF) begin
                t = 64'sh00000000FFFFFFFF;
                clipped = 1'b1;
            end
            pm_time = t[31:0];
        end
        r.pos_x = pm_x; r.pos_y = pm_y; r.heading = pm_h;
        r.elapsed_time = pm_time; r.saturated = clipped;
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // wait for every pending result, then let the block settle
    task automatic drain();
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk iff cfg_ready);
        case (idx)
            REG_TIME_STEP: pm_dt     = val[15:0];
            REG_INIT_X:    pm_init_x = val;
            REG_INIT_Y:    pm_init_y = val;
            REG_INIT_HEAD: pm_init_h = val[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input in_t d, input bit typed, input out_t want);
        int   gap;
        out_t p;
        gap = pick_gap(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk iff s_ready);
        p = advance_pose(d);
        pose_q.push_back(typed ? want : p);
    endtask

    function automatic in_t rand_item();
        in_t d;
        d.opcode = ($urandom_range(99) < 8) ? OP_LOAD : OP_STEP;
        case ($urandom_range(9))
            0:       d.speed = 16'sh7FFF;
            1:       d.speed = 16'sh8000;
            2:       d.speed = 16'($urandom_range(511));
            default: d.speed = 16'($urandom());
        endcase
        case ($urandom_range(5))
            0:       d.turn_rate = {$urandom_range(1) ? 24'h800000 : 24'h7FFFFF};
            1:       d.turn_rate = 24'($urandom_range(4095) - 2048);
            default: d.turn_rate = 24'($urandom());
        endcase
        return d;
    endfunction

    function automatic dir_row_t item_row(input logic op, input logic [15:0] spd,
                                          input logic [23:0] rate, input bit typed,
                                          input logic [31:0] x, input logic [31:0] y,
                                          input logic [15:0] h, input logic [31:0] t,
                                          input logic sat);
        dir_row_t r;
        r.is_cfg = 1'b0; r.idx = '0; r.val = '0;
        r.item.opcode = op; r.item.speed = spd; r.item.turn_rate = rate;
        r.typed = typed;
        r.want.pos_x = x; r.want.pos_y = y; r.want.heading = h;
        r.want.elapsed_time = t; r.want.saturated = sat;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                         input logic [31:0] val);
        dir_row_t r;
        r = item_row(OP_STEP, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0);
        r.is_cfg = 1'b1; r.idx = idx; r.val = val;
        return r;
    endfunction

    // result side: random back-pressure and checking
    always @(posedge aclk) begin
        out_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("unicycle_pose_integrator regression: fail");
            $finish;
        end
        if (m_stall > 0) begin
            m_stall <= m_stall - 1;
            m_ready <= 1'b0;
        end else if (m_calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) < 70);
            if ($urandom_range(99) < 3) m_stall <= $urandom_range(40, 8);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: result with none pending: %p", $realtime, m_data);
                err_cnt++;
            end else begin
                want = pose_q.pop_front();
                if (m_data.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x exp %h got %h", $realtime, want.pos_x, m_data.pos_x);
                    err_cnt++;
                end
                if (m_data.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y exp %h got %h", $realtime, want.pos_y, m_data.pos_y);
                    err_cnt++;
                end
                if (m_data.heading !== want.heading) begin
                    $display("%0t: heading exp %h got %h", $realtime, want.heading,
                             m_data.heading);
                    err_cnt++;
                end
                if (m_data.elapsed_time !== want.elapsed_time) begin
                    $display("%0t: elapsed_time exp %h got %h", $realtime,
                             want.elapsed_time, m_data.elapsed_time);
                    err_cnt++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $display("%0t: saturated exp %b got %b", $realtime, want.saturated,
                             m_data.saturated);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        bit     last_cfg;
        in_t    d;
        out_t   none;
        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        aresetn = 1'b0; err_cnt = 0; cycle_cnt = 0; m_stall = 0;
        s_calm = 1'b0; m_calm = 1'b0; none = '0;
        pm_dt = 16'd1638; pm_init_x = '0; pm_init_y = '0; pm_init_h = '0;
        pm_x = '0; pm_y = '0; pm_h = '0; pm_time = '0;

        // pose after reset, then extremes
        dir_tab.push_back(item_row(OP_STEP, 16'h0000, 24'h000000, 1'b1, '0, '0, '0,
                                   32'd1638, 1'b0));
        dir_tab.push_back(item_row(OP_LOAD, 16'h1234, 24'h123456, 1'b1, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h7FFF, 24'h7FFFFF, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h8000, 24'h800000, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h0100, 24'h028000, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h0100, 24'hFFFFFF, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_LOAD, 16'hFFFF, 24'hFFFFFF, 1'b1, '0, '0, '0,
                                   '0, 1'b0));
        // zero step holds the pose; out-of-range index is dropped
        dir_tab.push_back(cfg_row(REG_TIME_STEP, 32'h0000_0000));
        dir_tab.push_back(cfg_row(REG_INIT_X, 32'h7FFF_FFFF));
        dir_tab.push_back(cfg_row(REG_INIT_Y, 32'h8000_0000));
        dir_tab.push_back(cfg_row(REG_INIT_HEAD, 32'h0000_C000));
        dir_tab.push_back(cfg_row(8'hFF, 32'hFFFF_FFFF));
        dir_tab.push_back(cfg_row(8'h04, 32'h0000_0005));
        dir_tab.push_back(item_row(OP_LOAD, 16'h0000, 24'h000000, 1'b1, 32'h7FFFFFFF,
                                   32'h80000000, 16'hC000, '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h7FFF, 24'h7FFFFF, 1'b1, 32'h7FFFFFFF,
                                   32'h80000000, 16'hC000, '0, 1'b0));
        // max step drives both positions into the clip
        dir_tab.push_back(cfg_row(REG_TIME_STEP, 32'h0000_FFFF));
        dir_tab.push_back(item_row(OP_STEP, 16'h7FFF, 24'h000000, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h8000, 24'h400000, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h7FFF, 24'h7FFFFF, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h8000, 24'h800000, 1'b0, '0, '0, '0,
                                   '0, 1'b0));
        dir_tab.push_back(item_row(OP_STEP, 16'h00FF, 24'h0000FF, 1'b0, '0, '0, '0,
                                   '0, 1'b0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        last_cfg = 1'b1;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                if (!last_cfg) begin
                    s_valid <= 1'b0;
                    drain();
                end
                reg_write(dir_tab[i].idx, dir_tab[i].val);
                last_cfg = 1'b1;
            end else begin
                send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
                last_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            s_valid <= 1'b0;
            drain();
            s_calm = (ph == 2);
            m_calm = (ph == 4);
            case (ph)
                0: begin
                    reg_write(REG_TIME_STEP, 32'h0000_FFFF);
                    reg_write(REG_INIT_X, 32'h7FFF_FF00);
                    reg_write(REG_INIT_Y, 32'h8000_0100);
                    reg_write(REG_INIT_HEAD, 32'h0000_2000);
                end
                1: begin
                    reg_write(REG_TIME_STEP, 32'h0000_0001);
                    reg_write(REG_INIT_X, 32'hFFFF_FFFF);
                    reg_write(REG_INIT_Y, 32'h0000_0000);
                    reg_write(REG_INIT_HEAD, 32'h0000_FFFF);
                end
                default: begin
                    reg_write(REG_TIME_STEP, ($urandom_range(1)) ? $urandom()
                                                                 : $urandom_range(4095));
                    reg_write(REG_INIT_X, $urandom());
                    reg_write(REG_INIT_Y, $urandom());
                    reg_write(REG_INIT_HEAD, $urandom());
                end
            endcase
            reg_write(IDX_W'($urandom_range(255, 4)), $urandom());
            d = rand_item();
            d.opcode = OP_LOAD;
            send_item(d, 1'b0, none);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, none);
        end

        s_valid <= 1'b0;
        drain();
        if (err_cnt == 0) begin
            $display("unicycle_pose_integrator regression: pass");
        end else begin
            $display("unicycle_pose_integrator regression: fail");
        end
        $finish;
    end

endmodule

FILE: unicycle_pose_integrator.f
hw/rtl/upi_pkg.sv
hw/rtl/upi_cordic.sv
hw/rtl/unicycle_pose_integrator.sv
sim/unicycle_pose_integrator_tb.sv
